[hdl/nhsd_pkg.sv]
// ----------------------------------------------------------------------------
// nhsd_pkg
// Shared types and constants for the neighbor height standard deviation block.
// ----------------------------------------------------------------------------
package nhsd_pkg;

    // configuration of the datapath
    localparam int MAX_NEIGHBORS = 64;
    localparam int HEIGHT_BITS   = 24;

    // fixed field widths of the item channels
    localparam int HEIGHT_W = 24;
    localparam int VERTEX_W = 32;
    localparam int ROUGH_W  = 23;

    // derived widths
    localparam int LOG_MAX = $clog2(MAX_NEIGHBORS);
    localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int SUM_W   = HEIGHT_BITS + LOG_MAX;
    localparam int SQ_W    = 2 * (HEIGHT_BITS - 1) + LOG_MAX + 1;
    localparam int DIFF_W  = 2 * (HEIGHT_BITS - 1) + 2 * LOG_MAX + 1;
    localparam int NN_W    = 2 * CNT_W;
    localparam int HALF_W  = (SQ_W + 1) / 2;
    localparam int ROOT_W  = (DIFF_W + 1) / 2;
    localparam int SQIN_W  = 2 * ROOT_W;
    localparam int STEP_W  = $clog2(DIFF_W + 1);

    // largest roughness code
    localparam logic [ROUGH_W-1:0] ROUGH_MAX = '1;

    // input transaction
    typedef struct packed {
        logic signed [HEIGHT_W-1:0] neighbor_height;
        logic [VERTEX_W-1:0]        vertex_index;
        logic                       last_neighbor;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [VERTEX_W-1:0] result_vertex;
        logic [ROUGH_W-1:0]  roughness;
        logic                neighbor_overflow;
    } t_out_item;

    // one closed vertex, handed from the accumulator to the back end
    typedef struct packed {
        logic [VERTEX_W-1:0]    vertex;
        logic [CNT_W-1:0]       count;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]        sq_sum;
        logic                   overflow;
    } t_job;

    // job queue status
    typedef struct packed {
        logic full;
        logic valid;
    } t_job_q_stat;

    // back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUB,
        BK_DIV,
        BK_SQRT,
        BK_DONE
    } t_back_state;

endpackage

[hdl/neighbor_height_std_deviation.sv]
// ----------------------------------------------------------------------------
// neighbor_height_std_deviation
// Terrain roughness of a mesh vertex: population standard deviation of the
// heights of its neighbors, in unsigned Q15.8, floored.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: neighbor heights (signed Q16.8) arrive one transaction per
//   cycle with push/full; last_neighbor closes the vertex. Heights past the
//   neighbor limit are dropped and flagged in the result.
//   Result channel: one transaction per closed vertex with empty/pop; the
//   result on o_result is valid while empty is low.
// Throughput:
//   A height is accepted whenever full is low. Closing a vertex hands its
//   sums to a two-entry job queue; the back end finishes one vertex before
//   taking the next, running the one-bit-per-cycle restoring divider by n*n
//   followed by the two-bit-per-cycle square root. Heights of the following
//   vertices keep streaming in meanwhile; full rises only when both queue
//   entries wait for the back end.
// Reset: synchronous, active low; accumulators, queue pointers and the result
//   valid flag clear, and no result is pending afterwards.
// Stalls: while a result is not popped the back end holds its finished value
//   and the job queue fills, after which full holds off further heights.
// ----------------------------------------------------------------------------
module neighbor_height_std_deviation (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  nhsd_pkg::t_in_item    i_item,
    output logic                  empty,
    input  logic                  pop,
    output nhsd_pkg::t_out_item   o_result
);

    logic                   w_accept;
    logic                   w_job_push;
    logic                   w_job_pop;
    nhsd_pkg::t_job         w_job_in;
    nhsd_pkg::t_job         w_job_out;
    nhsd_pkg::t_job_q_stat  w_job_stat;

    assign full     = w_job_stat.full;
    assign w_accept = push && !w_job_stat.full;

    // height accumulator
    nhsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (i_item),
        .o_job_push (w_job_push),
        .o_job      (w_job_in)
    );

    // queue of closed vertices
    nhsd_job_q u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .i_pop   (w_job_pop),
        .o_job   (w_job_out),
        .o_stat  (w_job_stat)
    );

    // divide, square root and result register
    nhsd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_job_out),
        .i_job_stat (w_job_stat),
        .o_job_pop  (w_job_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule

[hdl/nhsd_front.sv]
// ----------------------------------------------------------------------------
// nhsd_front
// Accumulates count, sum and sum of squares of neighbor heights and closes a
// vertex into a job on its last height.
// ----------------------------------------------------------------------------
module nhsd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  nhsd_pkg::t_in_item    i_item,
    output logic                  o_job_push,
    output nhsd_pkg::t_job        o_job
);

    logic [nhsd_pkg::CNT_W-1:0]         r_count, n_count;
    logic signed [nhsd_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [nhsd_pkg::SQ_W-1:0]          r_sq_sum, n_sq_sum;
    logic                               r_ovf, n_ovf;

    logic signed [nhsd_pkg::HEIGHT_BITS-1:0]   w_h;
    logic signed [nhsd_pkg::SUM_W-1:0]         w_h_ext;
    logic signed [2*nhsd_pkg::HEIGHT_BITS-1:0] w_sq;
    logic                                      w_room;

    // height taken from its low bits, squared
    assign w_h     = signed'(i_item.neighbor_height[nhsd_pkg::HEIGHT_BITS-1:0]);
    assign w_h_ext = nhsd_pkg::SUM_W'(w_h);
    assign w_sq    = w_h * w_h;
    assign w_room  = r_count < nhsd_pkg::CNT_W'(nhsd_pkg::MAX_NEIGHBORS);

    // accumulate or flag overflow
    always_comb begin
        if (w_room) begin
            n_count  = r_count + nhsd_pkg::CNT_W'(1);
            n_sum    = r_sum + w_h_ext;
            n_sq_sum = r_sq_sum + nhsd_pkg::SQ_W'(unsigned'(w_sq));
            n_ovf    = r_ovf;
        end else begin
            n_count  = r_count;
            n_sum    = r_sum;
            n_sq_sum = r_sq_sum;
            n_ovf    = 1'b1;
        end
    end

    // job from the updated sums
    assign o_job_push    = i_accept && i_item.last_neighbor;
    assign o_job.vertex   = i_item.vertex_index;
    assign o_job.count    = n_count;
    assign o_job.sum      = n_sum;
    assign o_job.sq_sum   = n_sq_sum;
    assign o_job.overflow = n_ovf;

    // accumulator registers, cleared when a vertex closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_sq_sum <= '0;
            r_ovf    <= 1'b0;
        end else if (i_accept) begin
            if (i_item.last_neighbor) begin
                r_count  <= '0;
                r_sum    <= '0;
                r_sq_sum <= '0;
                r_ovf    <= 1'b0;
            end else begin
                r_count  <= n_count;
                r_sum    <= n_sum;
                r_sq_sum <= n_sq_sum;
                r_ovf    <= n_ovf;
            end
        end
    end

    // count never passes the neighbor limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= nhsd_pkg::CNT_W'(nhsd_pkg::MAX_NEIGHBORS))
        else $error("neighbor count above limit");

    // a closed vertex always holds at least one height
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> o_job.count != '0)
        else $error("empty job pushed");

endmodule

[hdl/nhsd_job_q.sv]
// ----------------------------------------------------------------------------
// nhsd_job_q
// Two-entry queue of closed vertices between the accumulator and back end.
// ----------------------------------------------------------------------------
module nhsd_job_q (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  nhsd_pkg::t_job         i_job,
    input  logic                   i_pop,
    output nhsd_pkg::t_job         o_job,
    output nhsd_pkg::t_job_q_stat  o_stat
);

    nhsd_pkg::t_job r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_level;

    logic w_push, w_pop;

    assign o_stat.full  = r_level == 2'd2;
    assign o_stat.valid = r_level != 2'd0;
    assign o_job        = r_slot[r_rd_ptr];

    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && o_stat.valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

[hdl/nhsd_back.sv]
// ----------------------------------------------------------------------------
// nhsd_back
// Per-vertex arithmetic: n*S2 - S1^2, restoring divide by n^2, digit-by-digit
// square root, saturation, and the result register.
// ----------------------------------------------------------------------------
module nhsd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  nhsd_pkg::t_job         i_job,
    input  nhsd_pkg::t_job_q_stat  i_job_stat,
    output logic                   o_job_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output nhsd_pkg::t_out_item    o_result
);

    localparam int SQ_REM_W  = nhsd_pkg::ROOT_W + 3;
    localparam int DIV_REM_W = nhsd_pkg::NN_W + 1;
    localparam int HI_W      = nhsd_pkg::SQ_W - nhsd_pkg::HALF_W;

    nhsd_pkg::t_back_state r_state, n_state;

    // latched job
    logic [nhsd_pkg::VERTEX_W-1:0]       r_vertex;
    logic                                r_ovf;
    logic [nhsd_pkg::CNT_W-1:0]          r_cnt;
    logic [nhsd_pkg::SUM_W-1:0]          r_s1_mag;
    logic [nhsd_pkg::SQ_W-1:0]           r_s2;

    // products
    logic [nhsd_pkg::HALF_W+nhsd_pkg::CNT_W-1:0] r_a_lo;
    logic [HI_W+nhsd_pkg::CNT_W-1:0]             r_a_hi;
    logic [nhsd_pkg::DIFF_W-1:0]                 r_b;
    logic [nhsd_pkg::NN_W-1:0]                   r_nn;

    // iteration state
    logic [nhsd_pkg::STEP_W-1:0]  r_step;
    logic [nhsd_pkg::DIFF_W-1:0]  r_work;
    logic [DIV_REM_W-1:0]         r_div_rem;
    logic [nhsd_pkg::SQIN_W-1:0]  r_sq_in;
    logic [SQ_REM_W-1:0]          r_sq_rem;
    logic [nhsd_pkg::ROOT_W-1:0]  r_root;

    // result register
    logic                 r_out_valid;
    nhsd_pkg::t_out_item  r_out;

    logic [nhsd_pkg::SUM_W-1:0]    w_s1_mag;
    logic [nhsd_pkg::DIFF_W-1:0]   w_a;
    logic [nhsd_pkg::DIFF_W-1:0]   w_diff;
    logic [DIV_REM_W-1:0]          w_div_rem;
    logic                          w_div_ge;
    logic [SQ_REM_W-1:0]           w_sq_rem;
    logic [SQ_REM_W-1:0]           w_sq_trial;
    logic                          w_sq_ge;
    logic [nhsd_pkg::ROOT_W+nhsd_pkg::ROUGH_W-1:0] w_root_ext;
    logic [nhsd_pkg::ROUGH_W-1:0]  w_rough;
    logic                          w_out_free;
    logic                          w_load_out;

    // magnitude of the height sum
    assign w_s1_mag = i_job.sum[nhsd_pkg::SUM_W-1] ? unsigned'(-i_job.sum)
                                                  : unsigned'(i_job.sum);

    // n*S2 from its two partial products, then clamped difference
    assign w_a = nhsd_pkg::DIFF_W'({r_a_hi, {nhsd_pkg::HALF_W{1'b0}}})
               + nhsd_pkg::DIFF_W'(r_a_lo);
    assign w_diff = (w_a > r_b) ? (w_a - r_b) : '0;

    // one restoring divide step
    assign w_div_rem = {r_div_rem[DIV_REM_W-2:0], r_work[nhsd_pkg::DIFF_W-1]};
    assign w_div_ge  = w_div_rem >= DIV_REM_W'(r_nn);

    // one square root step, two radicand bits at a time
    assign w_sq_rem   = {r_sq_rem[SQ_REM_W-3:0],
                         r_sq_in[nhsd_pkg::SQIN_W-1 -: 2]};
    assign w_sq_trial = SQ_REM_W'({r_root, 2'b01});
    assign w_sq_ge    = w_sq_rem >= w_sq_trial;

    // saturate to the roughness range
    assign w_root_ext = (nhsd_pkg::ROOT_W + nhsd_pkg::ROUGH_W)'(r_root);
    assign w_rough = (w_root_ext > (nhsd_pkg::ROOT_W + nhsd_pkg::ROUGH_W)'(nhsd_pkg::ROUGH_MAX))
                   ? nhsd_pkg::ROUGH_MAX
                   : w_root_ext[nhsd_pkg::ROUGH_W-1:0];

    assign w_out_free = !r_out_valid || i_pop;

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        o_job_pop  = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            nhsd_pkg::BK_IDLE: begin
                if (i_job_stat.valid) begin
                    o_job_pop = 1'b1;
                    n_state   = nhsd_pkg::BK_MUL;
                end
            end
            nhsd_pkg::BK_MUL: begin
                n_state = nhsd_pkg::BK_SUB;
            end
            nhsd_pkg::BK_SUB: begin
                n_state = nhsd_pkg::BK_DIV;
            end
            nhsd_pkg::BK_DIV: begin
                if (r_step == nhsd_pkg::STEP_W'(nhsd_pkg::DIFF_W - 1)) begin
                    n_state = nhsd_pkg::BK_SQRT;
                end
            end
            nhsd_pkg::BK_SQRT: begin
                if (r_step == nhsd_pkg::STEP_W'(nhsd_pkg::ROOT_W - 1)) begin
                    n_state = nhsd_pkg::BK_DONE;
                end
            end
            nhsd_pkg::BK_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = nhsd_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = nhsd_pkg::BK_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nhsd_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            nhsd_pkg::BK_IDLE: begin
                r_vertex <= i_job.vertex;
                r_ovf    <= i_job.overflow;
                r_cnt    <= i_job.count;
                r_s1_mag <= w_s1_mag;
                r_s2     <= i_job.sq_sum;
            end
            nhsd_pkg::BK_MUL: begin
                r_a_lo <= r_s2[nhsd_pkg::HALF_W-1:0] * r_cnt;
                r_a_hi <= r_s2[nhsd_pkg::SQ_W-1:nhsd_pkg::HALF_W] * r_cnt;
                r_b    <= nhsd_pkg::DIFF_W'(r_s1_mag * r_s1_mag);
                r_nn   <= r_cnt * r_cnt;
            end
            nhsd_pkg::BK_SUB: begin
                r_work    <= w_diff;
                r_div_rem <= '0;
                r_step    <= '0;
            end
            nhsd_pkg::BK_DIV: begin
                r_div_rem <= w_div_ge ? (w_div_rem - DIV_REM_W'(r_nn)) : w_div_rem;
                r_work    <= {r_work[nhsd_pkg::DIFF_W-2:0], w_div_ge};
                if (r_step == nhsd_pkg::STEP_W'(nhsd_pkg::DIFF_W - 1)) begin
                    r_step   <= '0;
                    r_sq_in  <= nhsd_pkg::SQIN_W'({r_work[nhsd_pkg::DIFF_W-2:0],
                                                   w_div_ge});
                    r_sq_rem <= '0;
                    r_root   <= '0;
                end else begin
                    r_step <= r_step + nhsd_pkg::STEP_W'(1);
                end
            end
            nhsd_pkg::BK_SQRT: begin
                r_sq_in  <= {r_sq_in[nhsd_pkg::SQIN_W-3:0], 2'b00};
                r_sq_rem <= w_sq_ge ? (w_sq_rem - w_sq_trial) : w_sq_rem;
                r_root   <= {r_root[nhsd_pkg::ROOT_W-2:0], w_sq_ge};
                r_step   <= r_step + nhsd_pkg::STEP_W'(1);
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.result_vertex     <= r_vertex;
            r_out.roughness         <= w_rough;
            r_out.neighbor_overflow <= r_ovf;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    // divisor n*n is never zero while dividing
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nhsd_pkg::BK_DIV) |-> r_nn != '0)
        else $error("divide by zero");

    // divider partial remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nhsd_pkg::BK_DIV) |-> r_div_rem < DIV_REM_W'(r_nn))
        else $error("divider remainder out of range");

    // square root remainder never exceeds twice the partial root
    a_sq_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nhsd_pkg::BK_SQRT) |-> r_sq_rem <= SQ_REM_W'({r_root, 1'b0}))
        else $error("root remainder out of range");

    // a job is taken only when the sequencer was idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> r_state == nhsd_pkg::BK_MUL)
        else $error("job taken outside idle");

endmodule
